### src/hsvrgb_pkg.sv
// Shared types and constants for the HSV to RGB pipeline.
// No dependencies; imported by every module of the block.
`default_nettype none

package hsvrgb_pkg;

    // Channel width, all levels use 65535 as full scale
    localparam int LVL_W = 16;
    // Hue times six: 3 sector bits over 16 fraction bits
    localparam int H6_W  = 19;
    localparam int SEC_W = 3;
    localparam int PRD_W = 2 * LVL_W;
    localparam int DATA_W = 3 * LVL_W;

    localparam logic [LVL_W-1:0] LVL_ONE = {LVL_W{1'b1}};

    // Hue sectors, named by the color at their start
    localparam logic [SEC_W-1:0] SEC_RED     = 3'd0;
    localparam logic [SEC_W-1:0] SEC_YELLOW  = 3'd1;
    localparam logic [SEC_W-1:0] SEC_GREEN   = 3'd2;
    localparam logic [SEC_W-1:0] SEC_CYAN    = 3'd3;
    localparam logic [SEC_W-1:0] SEC_BLUE    = 3'd4;
    localparam logic [SEC_W-1:0] SEC_MAGENTA = 3'd5;

    // Stage tag that travels with each word
    typedef struct packed {
        logic             vld;
        logic [SEC_W-1:0] sector;
    } t_tag;

endpackage

`default_nettype wire

### src/hsvrgb_front.sv
// Stage 1: input register, hue times six split into sector and fraction.
// Depends on hsvrgb_pkg.
`default_nettype none

module hsvrgb_front
    import hsvrgb_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_valid,
    output logic                  o_ready,
    input  wire logic [LVL_W-1:0] i_hue,
    input  wire logic [LVL_W-1:0] i_sat,
    input  wire logic [LVL_W-1:0] i_val,
    output t_tag                  o_tag,
    output logic [LVL_W-1:0]      o_frac,
    output logic [LVL_W-1:0]      o_sat,
    output logic [LVL_W-1:0]      o_inv_sat,
    output logic [LVL_W-1:0]      o_val,
    input  wire logic             i_ready
);

    logic             r_vld;
    logic [SEC_W-1:0] r_sector;
    logic [LVL_W-1:0] r_frac;
    logic [LVL_W-1:0] r_sat;
    logic [LVL_W-1:0] r_inv_sat;
    logic [LVL_W-1:0] r_val;
    logic [H6_W-1:0]  h6;
    logic             load;

    // hue * 6 as two shifted adds
    assign h6 = {1'b0, i_hue, 2'b00} + {2'b00, i_hue, 1'b0};

    assign o_ready = !r_vld || i_ready;
    assign load    = o_ready && i_valid;

    // Valid bit
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_valid;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_sector  <= h6[H6_W-1:LVL_W];
            r_frac    <= h6[LVL_W-1:0];
            r_sat     <= i_sat;
            r_inv_sat <= LVL_ONE - i_sat;
            r_val     <= i_val;
        end
    end

    assign o_tag.vld    = r_vld;
    assign o_tag.sector = r_sector;
    assign o_frac       = r_frac;
    assign o_sat        = r_sat;
    assign o_inv_sat    = r_inv_sat;
    assign o_val        = r_val;

endmodule

`default_nettype wire

### src/hsvrgb_mult.sv
// Stages 2 and 3: saturation products, then brightness products.
// Depends on hsvrgb_pkg.
`default_nettype none

module hsvrgb_mult
    import hsvrgb_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_tag             i_tag,
    output logic                  o_ready,
    input  wire logic [LVL_W-1:0] i_frac,
    input  wire logic [LVL_W-1:0] i_sat,
    input  wire logic [LVL_W-1:0] i_inv_sat,
    input  wire logic [LVL_W-1:0] i_val,
    output t_tag                  o_tag,
    output logic [PRD_W-1:0]      o_low_p,
    output logic [PRD_W-1:0]      o_fall_p,
    output logic [PRD_W-1:0]      o_rise_p,
    output logic [LVL_W-1:0]      o_val,
    input  wire logic             i_ready
);

    // Stage 2 registers
    logic             r_vld2;
    logic [SEC_W-1:0] r_sec2;
    logic [LVL_W-1:0] r_tfall;
    logic [LVL_W-1:0] r_trise;
    logic [PRD_W-1:0] r_low_p2;
    logic [LVL_W-1:0] r_val2;
    // Stage 3 registers
    logic             r_vld3;
    logic [SEC_W-1:0] r_sec3;
    logic [PRD_W-1:0] r_low_p3;
    logic [PRD_W-1:0] r_fall_p;
    logic [PRD_W-1:0] r_rise_p;
    logic [LVL_W-1:0] r_val3;

    logic             rdy2;
    logic             rdy3;
    logic [LVL_W:0]   frac_rem;
    logic [PRD_W:0]   trise_p;
    logic [PRD_W-1:0] tfall_p;

    assign rdy3    = !r_vld3 || i_ready;
    assign rdy2    = !r_vld2 || rdy3;
    assign o_ready = rdy2;

    // Distance to the end of the sector, 1 .. 65536
    assign frac_rem = {1'b1, {LVL_W{1'b0}}} - {1'b0, i_frac};
    assign tfall_p  = i_sat * i_frac;
    assign trise_p  = {1'b0, i_sat} * frac_rem;

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld2 <= 1'b0;
            r_vld3 <= 1'b0;
        end else begin
            if (rdy2) begin
                r_vld2 <= i_tag.vld;
            end
            if (rdy3) begin
                r_vld3 <= r_vld2;
            end
        end
    end

    // Stage 2: sat * frac, sat * (1 - frac), val * (1 - sat)
    always_ff @(posedge i_clk) begin
        if (rdy2 && i_tag.vld) begin
            r_sec2   <= i_tag.sector;
            r_tfall  <= tfall_p[PRD_W-1:LVL_W];
            r_trise  <= trise_p[PRD_W-1:LVL_W];
            r_low_p2 <= i_val * i_inv_sat;
            r_val2   <= i_val;
        end
    end

    // Stage 3: val * (1 - t) for the falling and rising channels
    always_ff @(posedge i_clk) begin
        if (rdy3 && r_vld2) begin
            r_sec3   <= r_sec2;
            r_low_p3 <= r_low_p2;
            r_fall_p <= r_val2 * (LVL_ONE - r_tfall);
            r_rise_p <= r_val2 * (LVL_ONE - r_trise);
            r_val3   <= r_val2;
        end
    end

    assign o_tag.vld    = r_vld3;
    assign o_tag.sector = r_sec3;
    assign o_low_p      = r_low_p3;
    assign o_fall_p     = r_fall_p;
    assign o_rise_p     = r_rise_p;
    assign o_val        = r_val3;

    // Hue times six never reaches a seventh sector
    a_sector_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld2 |-> (r_sec2 <= SEC_MAGENTA))
        else $error("sector out of range");

    // Scaled products never exceed the brightness
    a_fall_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld3 |-> (r_fall_p[PRD_W-1:LVL_W] <= r_val3))
        else $error("fall product above brightness");

    a_rise_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld3 |-> (r_rise_p[PRD_W-1:LVL_W] <= r_val3))
        else $error("rise product above brightness");

endmodule

`default_nettype wire

### src/hsvrgb_mix.sv
// Stage 4: divide products by full scale, route channels by sector, output register.
// Depends on hsvrgb_pkg.
`default_nettype none

module hsvrgb_mix
    import hsvrgb_pkg::*;
(
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire t_tag             i_tag,
    output logic                  o_ready,
    input  wire logic [PRD_W-1:0] i_low_p,
    input  wire logic [PRD_W-1:0] i_fall_p,
    input  wire logic [PRD_W-1:0] i_rise_p,
    input  wire logic [LVL_W-1:0] i_val,
    output logic                  o_valid,
    output logic [DATA_W-1:0]     o_data,
    input  wire logic             i_ready
);

    // floor(x / 65535) for x <= 65535^2: x = q*65535 + (q + lo)
    function automatic logic [LVL_W-1:0] f_div_one(input logic [PRD_W-1:0] x);
        logic [LVL_W:0] s;
        s = {1'b0, x[PRD_W-1:LVL_W]} + {1'b0, x[LVL_W-1:0]};
        if (s >= {LVL_ONE, 1'b0}) begin
            return x[PRD_W-1:LVL_W] + 16'd2;
        end else if (s >= {1'b0, LVL_ONE}) begin
            return x[PRD_W-1:LVL_W] + 16'd1;
        end else begin
            return x[PRD_W-1:LVL_W];
        end
    endfunction

    logic             r_vld;
    logic [LVL_W-1:0] r_red;
    logic [LVL_W-1:0] r_green;
    logic [LVL_W-1:0] r_blue;
    logic [LVL_W-1:0] low;
    logic [LVL_W-1:0] fall;
    logic [LVL_W-1:0] rise;
    logic [LVL_W-1:0] n_red;
    logic [LVL_W-1:0] n_green;
    logic [LVL_W-1:0] n_blue;

    assign o_ready = !r_vld || i_ready;

    assign low  = f_div_one(i_low_p);
    assign fall = f_div_one(i_fall_p);
    assign rise = f_div_one(i_rise_p);

    // Channel routing; black and grey fall out of the products directly
    always_comb begin
        unique case (i_tag.sector)
            SEC_RED: begin
                n_red = i_val; n_green = rise;  n_blue = low;
            end
            SEC_YELLOW: begin
                n_red = fall;  n_green = i_val; n_blue = low;
            end
            SEC_GREEN: begin
                n_red = low;   n_green = i_val; n_blue = rise;
            end
            SEC_CYAN: begin
                n_red = low;   n_green = fall;  n_blue = i_val;
            end
            SEC_BLUE: begin
                n_red = rise;  n_green = low;   n_blue = i_val;
            end
            default: begin
                n_red = i_val; n_green = low;   n_blue = fall;
            end
        endcase
    end

    // Output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_ready) begin
            r_vld <= i_tag.vld;
        end
    end

    // Output word
    always_ff @(posedge i_clk) begin
        if (o_ready && i_tag.vld) begin
            r_red   <= n_red;
            r_green <= n_green;
            r_blue  <= n_blue;
        end
    end

    assign o_valid = r_vld;
    assign o_data  = {r_blue, r_green, r_red};

endmodule

`default_nettype wire

### src/hsv_to_rgb_unit.sv
// Top level of the HSV to RGB converter: four-stage pipeline.
// Depends on hsvrgb_pkg, hsvrgb_front, hsvrgb_mult, hsvrgb_mix.
//
//  Channel   Dir   Word (low bits first)
//  s stream  in    hue_turn[15:0], sat_level[31:16], bright_level[47:32]
//  m stream  out   red_level[15:0], green_level[31:16], blue_level[47:32]
//
// One word per clock while the output side is ready; four register stages
// (input split, saturation multiply, brightness multiply, divide and route).
// Each stage has its own valid bit and advances when empty or when the next one
// takes its word, so bubbles close up and a stall loses nothing.
// Synchronous active-low reset clears all valid bits; no state beyond the pipe.
`default_nettype none

module hsv_to_rgb_unit
    import hsvrgb_pkg::*;
(
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_s_tvalid,
    output logic                   o_s_tready,
    input  wire logic [DATA_W-1:0] i_s_tdata,  // hue_turn, sat_level, bright_level
    output logic                   o_m_tvalid,
    input  wire logic              i_m_tready,
    output logic [DATA_W-1:0]      o_m_tdata   // red_level, green_level, blue_level
);

    t_tag             tag1;
    t_tag             tag3;
    logic             rdy_mult;
    logic             rdy_mix;
    logic [LVL_W-1:0] frac1;
    logic [LVL_W-1:0] sat1;
    logic [LVL_W-1:0] inv_sat1;
    logic [LVL_W-1:0] val1;
    logic [PRD_W-1:0] low_p3;
    logic [PRD_W-1:0] fall_p3;
    logic [PRD_W-1:0] rise_p3;
    logic [LVL_W-1:0] val3;

    // Input split
    hsvrgb_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_hue     (i_s_tdata[LVL_W-1:0]),
        .i_sat     (i_s_tdata[2*LVL_W-1:LVL_W]),
        .i_val     (i_s_tdata[3*LVL_W-1:2*LVL_W]),
        .o_tag     (tag1),
        .o_frac    (frac1),
        .o_sat     (sat1),
        .o_inv_sat (inv_sat1),
        .o_val     (val1),
        .i_ready   (rdy_mult)
    );

    // Multiplier stages
    hsvrgb_mult u_mult (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_tag     (tag1),
        .o_ready   (rdy_mult),
        .i_frac    (frac1),
        .i_sat     (sat1),
        .i_inv_sat (inv_sat1),
        .i_val     (val1),
        .o_tag     (tag3),
        .o_low_p   (low_p3),
        .o_fall_p  (fall_p3),
        .o_rise_p  (rise_p3),
        .o_val     (val3),
        .i_ready   (rdy_mix)
    );

    // Divide, route and output register
    hsvrgb_mix u_mix (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_tag    (tag3),
        .o_ready  (rdy_mix),
        .i_low_p  (low_p3),
        .i_fall_p (fall_p3),
        .i_rise_p (rise_p3),
        .i_val    (val3),
        .o_valid  (o_m_tvalid),
        .o_data   (o_m_tdata),
        .i_ready  (i_m_tready)
    );

endmodule

`default_nettype wire
